// ===== hw/rtl/arhc_pkg.sv =====
package arhc_pkg;

   // Default frame capacity in cells.
   localparam int MaxCellsDef = 4096;

   // Field widths of the two channels.
   localparam int CmdW    = 2;
   localparam int SampleW = 32;
   localparam int IndexW  = 12;
   localparam int ChanW   = 8;

   // Commands carried on the request channel.
   typedef enum logic [CmdW-1:0] {
      CMD_START = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_FETCH = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Colour stop positions, unsigned with 16 fraction bits (65536 is 1.0).
   localparam logic [16:0] STOP_POS [8] = '{
      17'd0, 17'd9175, 17'd19661, 17'd28836,
      17'd38011, 17'd45875, 17'd55050, 17'd65536
   };

   // Colour of each stop as 0xRRGGBB.
   localparam logic [23:0] STOP_RGB [8] = '{
      24'h000018, 24'h001070, 24'h003b88, 24'h00721b,
      24'h49bd00, 24'hc2d100, 24'hd88900, 24'hbf4a00
   };

   // Fixed colours for an absent cell and for an empty range.
   localparam logic [23:0] GREY_RGB   = 24'he5e7eb;
   localparam logic [23:0] ORANGE_RGB = 24'hd97800;

endpackage

// ===== hw/rtl/auto_range_heatmap_colormap.sv =====
// Channel   | Direction | Beat contents
// ----------+-----------+------------------------------------------------
// req_      | in        | cmd, sample, present, cell_index
// rsp_      | out       | red, green, blue (one beat for each fetch)
//
// A start or load beat is taken in the idle state. A mapped fetch runs through
// one memory read, 17 steps of the restoring divider for the ratio, one
// segment lookup, one multiply, 8 steps of the blend divider and the output load.
// A fetch of an absent cell or over an empty range skips to the output load.
// Reset is synchronous and clears the frame counters; the cell memory is not
// cleared. A new request is taken while an earlier result still waits on rsp_,
// and a finished fetch stalls until that earlier result is taken.
module auto_range_heatmap_colormap #(
   parameter int MAX_CELLS = arhc_pkg::MaxCellsDef
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [arhc_pkg::CmdW-1:0]           req_cmd,
   input  logic signed [arhc_pkg::SampleW-1:0] req_sample,
   input  logic                                req_present,
   input  logic [arhc_pkg::IndexW-1:0]         req_cell_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [arhc_pkg::ChanW-1:0]          rsp_red,
   output logic [arhc_pkg::ChanW-1:0]          rsp_green,
   output logic [arhc_pkg::ChanW-1:0]          rsp_blue
);
   import arhc_pkg::*;

   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CW = $clog2(MAX_CELLS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DIV, ST_SEG, ST_MUL, ST_BLEND, ST_OUT
   } state_type;

   state_type state_ff;

   // Cell memory: present bit over the sample.
   logic [32:0] mem [MAX_CELLS];
   logic [32:0] rd_ff;

   logic [CW-1:0]      loaded_ff;
   logic signed [31:0] min_ff, max_ff;
   logic               any_ff;
   logic               in_range_ff;

   logic accept, is_load, can_load;
   logic rsp_load;

   // Ratio divider.
   logic [33:0] rem_ff;
   logic [32:0] den_ff;
   logic [16:0] q_ff;
   logic [4:0]  cnt_ff;

   // Segment and blend.
   logic [2:0]  k_ff;
   logic [13:0] d_ff, dt_ff;
   logic [23:0] ln_rem_ff [3];
   logic [23:0] dsh_ff;
   logic [7:0]  ln_q_ff [3];

   logic [23:0] pend_ff;
   logic        rsp_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff;

   assign accept   = req_valid & req_ready;
   assign is_load  = accept && (req_cmd == CMD_LOAD);
   assign can_load = (loaded_ff != CW'(MAX_CELLS));
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // Cell memory: one write port for loads, one registered read for fetches.
   // The read data is held from the accepted beat until the fetch is done.
   always_ff @(posedge clock) begin
      if (is_load && can_load) begin
         mem[loaded_ff[AW-1:0]] <= {req_present, req_sample};
      end
      if (accept) begin
         rd_ff <= mem[AW'(req_cell_index)];
      end
   end

   // Frame counters and running extremes.
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         any_ff    <= 1'b0;
      end else if (accept && (req_cmd == CMD_START)) begin
         loaded_ff <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         any_ff    <= 1'b0;
      end else if (is_load && can_load) begin
         loaded_ff <= loaded_ff + CW'(1);
         if (req_present) begin
            any_ff <= 1'b1;
            if (!any_ff || (req_sample < min_ff)) begin
               min_ff <= req_sample;
            end
            if (!any_ff || (req_sample > max_ff)) begin
               max_ff <= req_sample;
            end
         end
      end
   end

   // Range, clamped numerator and the empty-range test on the read data.
   logic signed [33:0] lo_s, hi_s, den_s, num_s, v_s;
   logic [33:0]        num_c;
   always_comb begin
      lo_s  = any_ff ? {{2{min_ff[31]}}, min_ff} : 34'sd0;
      hi_s  = any_ff ? {{2{max_ff[31]}}, max_ff} : 34'sd1;
      v_s   = {{2{rd_ff[31]}}, rd_ff[31:0]};
      den_s = hi_s - lo_s;
      num_s = v_s - lo_s;
      if (num_s < 0) begin
         num_c = '0;
      end else if (num_s > den_s) begin
         num_c = den_s;
      end else begin
         num_c = num_s;
      end
   end

   // One restoring step of the ratio divider.
   logic        div_ge;
   logic [33:0] div_rem;
   always_comb begin
      div_ge  = (rem_ff >= {1'b0, den_ff});
      div_rem = div_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   end

   // Segment search: first stop at or above t.
   logic [2:0] k_c;
   always_comb begin
      k_c = 3'd7;
      for (int j = 6; j >= 1; j--) begin
         if (q_ff <= STOP_POS[j]) begin
            k_c = 3'(j);
         end
      end
   end

   // Blend numerators for the three channels.
   logic [23:0] ln_num [3];
   always_comb begin
      logic [7:0]         a, b;
      logic signed [8:0]  diff;
      logic signed [24:0] pa, pb, sc;
      for (int ch = 0; ch < 3; ch++) begin
         a    = STOP_RGB[3'(k_ff - 3'd1)][23 - 8*ch -: 8];
         b    = STOP_RGB[k_ff][23 - 8*ch -: 8];
         diff = $signed({1'b0, b}) - $signed({1'b0, a});
         pa   = $signed({17'b0, a}) * $signed({11'b0, d_ff});
         pb   = $signed({{16{diff[8]}}, diff}) * $signed({11'b0, dt_ff});
         sc   = pa + pb;
         ln_num[ch] = {sc[22:0], 1'b0} + 24'(d_ff);
      end
   end

   // Sequencer with the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         // The result register refills from ST_OUT or empties when its beat is taken.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_cmd == CMD_FETCH)) begin
                  in_range_ff <= (32'(req_cell_index) < 32'(loaded_ff));
                  state_ff    <= ST_READ;
               end
            end
            ST_READ: begin
               if (!in_range_ff || !rd_ff[32]) begin
                  pend_ff  <= GREY_RGB;
                  state_ff <= ST_OUT;
               end else if (hi_s <= lo_s) begin
                  pend_ff  <= ORANGE_RGB;
                  state_ff <= ST_OUT;
               end else begin
                  rem_ff   <= num_c;
                  den_ff   <= den_s[32:0];
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= {div_rem[32:0], 1'b0};
               q_ff   <= {q_ff[15:0], div_ge};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd16) begin
                  state_ff <= ST_SEG;
               end
            end
            ST_SEG: begin
               k_ff     <= k_c;
               d_ff     <= 14'(STOP_POS[k_c] - STOP_POS[3'(k_c - 3'd1)]);
               dt_ff    <= 14'(q_ff - STOP_POS[3'(k_c - 3'd1)]);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               for (int ch = 0; ch < 3; ch++) begin
                  ln_rem_ff[ch] <= ln_num[ch];
                  ln_q_ff[ch]   <= '0;
               end
               dsh_ff   <= {3'b0, d_ff, 7'b0} << 1;
               cnt_ff   <= '0;
               state_ff <= ST_BLEND;
            end
            ST_BLEND: begin
               for (int ch = 0; ch < 3; ch++) begin
                  if (ln_rem_ff[ch] >= dsh_ff) begin
                     ln_rem_ff[ch] <= ln_rem_ff[ch] - dsh_ff;
                     ln_q_ff[ch]   <= {ln_q_ff[ch][6:0], 1'b1};
                  end else begin
                     ln_q_ff[ch]   <= {ln_q_ff[ch][6:0], 1'b0};
                  end
               end
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd7) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_load) begin
                  if (in_range_ff && rd_ff[32] && !(hi_s <= lo_s)) begin
                     red_ff   <= ln_q_ff[0];
                     green_ff <= ln_q_ff[1];
                     blue_ff  <= ln_q_ff[2];
                  end else begin
                     red_ff   <= pend_ff[23:16];
                     green_ff <= pend_ff[15:8];
                     blue_ff  <= pend_ff[7:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
